// ===== hdl/urrb_pkg.sv =====
`timescale 1ns / 1ps

package urrb_pkg;

    localparam int BUFFER_DEPTH = 64;
    localparam int IDX_W        = $clog2(BUFFER_DEPTH);
    localparam int FILL_W       = 6;
    localparam int DELAY_W      = 14;
    localparam int CFG_DATA_W   = 14;
    localparam int CFG_IDX_W    = 3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUFFER_DEPTH - 1);

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_DELAY = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BIT_DELAY    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_DELAY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INVERT_LINE  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RX_ENABLE    = 3'd4;

    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_READ  = 2'd1,
        REQ_PEEK  = 2'd2,
        REQ_FLUSH = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_CENTER = 2'd1,
        PH_DATA   = 2'd2,
        PH_STOP   = 2'd3
    } phase_t;

    typedef struct packed {
        req_t req_type;
        logic rx_level;
    } in_item_t;

    typedef struct packed {
        logic              data_valid;
        logic [7:0]        data_byte;
        logic [FILL_W-1:0] fill_count;
        logic              overflow;
        logic              byte_stored;
        logic              receiving;
    } out_item_t;

    typedef struct packed {
        logic [DELAY_W-1:0] center_delay;
        logic [DELAY_W-1:0] bit_delay;
        logic [DELAY_W-1:0] stop_delay;
        logic               invert_line;
        logic               rx_enable;
    } rx_cfg_t;

    typedef struct packed {
        logic       done;
        logic [7:0] data;
        logic       busy;
    } rx_evt_t;

    function automatic logic [IDX_W-1:0] next_index(input logic [IDX_W-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [FILL_W-1:0] buffered(input logic [IDX_W-1:0] w,
                                                   input logic [IDX_W-1:0] r);
        logic [IDX_W:0] cnt;
        cnt = {1'b0, w} - {1'b0, r};
        if (w < r)
        begin
            cnt = cnt + (IDX_W+1)'(BUFFER_DEPTH);
        end
        return FILL_W'(cnt);
    endfunction

endpackage

// ===== hdl/uart_receiver_with_ring_buffer.sv =====
`timescale 1ns / 1ps
// A result is in the output register in the cycle after its input beat is accepted.
// Throughput: one beat per cycle; input stalls only while a result waits unread.
// Read and peek data comes from the registered read port of the byte RAM.
// Reset (async, rst_n low) clears indices, flags, frame state and config registers
// to their defaults; the byte RAM is not cleared, no clearing pass is needed.
module uart_receiver_with_ring_buffer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  urrb_pkg::in_item_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output urrb_pkg::out_item_t                 out_data,
    input  logic                                cfg_we,
    input  logic [urrb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [urrb_pkg::CFG_DATA_W-1:0]     cfg_data
);

    import urrb_pkg::*;

    rx_cfg_t           cfg_reg;
    rx_evt_t           evt;
    logic [IDX_W-1:0]  rd_idx_reg, rd_idx_next, rd_host;
    logic [IDX_W-1:0]  wr_idx_reg, wr_idx_next, wr_host;
    logic              dropped_reg, dropped_next;
    logic              accept;
    logic              host_rd;
    logic              host_flush;
    logic              store;
    logic              out_valid_reg;
    out_item_t         res_reg, res_next;
    logic [7:0]        ram_rdata;

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    urrb_rx u_rx (
        .clk   (clk),
        .rst_n (rst_n),
        .tick  (accept),
        .level (in_data.rx_level),
        .cfg   (cfg_reg),
        .evt   (evt)
    );

    // host request acts on the buffer before the receiver tick
    always_comb
    begin
        host_rd    = cfg_reg.rx_enable && (in_data.req_type inside {REQ_READ, REQ_PEEK})
                     && (rd_idx_reg != wr_idx_reg);
        host_flush = cfg_reg.rx_enable && (in_data.req_type == REQ_FLUSH);
        rd_host    = rd_idx_reg;
        wr_host    = wr_idx_reg;
        if (host_rd && in_data.req_type == REQ_READ)
        begin
            rd_host = next_index(rd_idx_reg);
        end
        else if (host_flush)
        begin
            rd_host = '0;
            wr_host = '0;
        end
        store        = evt.done && (next_index(wr_host) != rd_host);
        rd_idx_next  = rd_host;
        wr_idx_next  = store ? next_index(wr_host) : wr_host;
        dropped_next = dropped_reg | (evt.done && !store);

        res_next.data_valid  = host_rd;
        res_next.data_byte   = '0;
        res_next.fill_count  = cfg_reg.rx_enable ? buffered(wr_idx_next, rd_idx_next) : '0;
        res_next.overflow    = dropped_next;
        res_next.byte_stored = store;
        res_next.receiving   = evt.busy;
    end

    urrb_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (accept && store),
        .waddr (wr_host),
        .wdata (evt.data),
        .re    (accept && host_rd),
        .raddr (rd_idx_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.center_delay <= DELAY_W'(114);
            cfg_reg.bit_delay    <= DELAY_W'(236);
            cfg_reg.stop_delay   <= DELAY_W'(236);
            cfg_reg.invert_line  <= 1'b0;
            cfg_reg.rx_enable    <= 1'b1;
            rd_idx_reg           <= '0;
            wr_idx_reg           <= '0;
            dropped_reg          <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                rd_idx_reg  <= rd_idx_next;
                wr_idx_reg  <= wr_idx_next;
                dropped_reg <= dropped_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_CENTER_DELAY: cfg_reg.center_delay <= cfg_data[DELAY_W-1:0];
                    CFG_BIT_DELAY:    cfg_reg.bit_delay    <= cfg_data[DELAY_W-1:0];
                    CFG_STOP_DELAY:   cfg_reg.stop_delay   <= cfg_data[DELAY_W-1:0];
                    CFG_INVERT_LINE:  cfg_reg.invert_line  <= cfg_data[0];
                    CFG_RX_ENABLE:
                    begin
                        // re-enable empties the buffer and clears overflow
                        if (cfg_data[0] && !cfg_reg.rx_enable)
                        begin
                            rd_idx_reg  <= '0;
                            wr_idx_reg  <= '0;
                            dropped_reg <= 1'b0;
                        end
                        cfg_reg.rx_enable <= cfg_data[0];
                    end
                    default:
                    begin
                        cfg_reg <= cfg_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;

    always_comb
    begin
        out_data           = res_reg;
        out_data.data_byte = res_reg.data_valid ? ram_rdata : 8'd0;
    end

endmodule

// ===== hdl/urrb_ram.sv =====
`timescale 1ns / 1ps

module urrb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/urrb_rx.sv =====
`timescale 1ns / 1ps

module urrb_rx (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            tick,
    input  logic            level,
    input  urrb_pkg::rx_cfg_t cfg,
    output urrb_pkg::rx_evt_t evt
);

    import urrb_pkg::*;

    phase_t             phase_reg, phase_next;
    logic [DELAY_W-1:0] tick_reg, tick_next;
    logic [2:0]         bit_reg, bit_next;
    logic [7:0]         shift_reg, shift_next;
    logic               last_reg;
    logic               delay_done;
    logic               start_edge;

    // a delay of 0 or 1 ends on this tick
    assign delay_done = (tick_reg <= DELAY_W'(1));
    assign start_edge = (level != last_reg) && (level == cfg.invert_line);

    always_comb
    begin
        phase_next = phase_reg;
        if (!cfg.rx_enable)
        begin
            phase_next = PH_IDLE;
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:   if (start_edge) phase_next = PH_CENTER;
                PH_CENTER: if (delay_done) phase_next = PH_DATA;
                PH_DATA:   if (delay_done && bit_reg == 3'd7) phase_next = PH_STOP;
                PH_STOP:   if (delay_done) phase_next = PH_IDLE;
                default:   phase_next = PH_IDLE;
            endcase
        end
    end

    always_comb
    begin
        tick_next  = tick_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        evt.done   = 1'b0;
        evt.data   = cfg.invert_line ? ~shift_reg : shift_reg;
        evt.busy   = (phase_next != PH_IDLE);
        if (cfg.rx_enable)
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    if (start_edge)
                    begin
                        tick_next  = cfg.center_delay;
                        bit_next   = '0;
                        shift_next = '0;
                    end
                end
                PH_CENTER:
                begin
                    tick_next = delay_done ? cfg.bit_delay : tick_reg - 1'b1;
                end
                PH_DATA:
                begin
                    if (delay_done)
                    begin
                        shift_next[bit_reg] = shift_reg[bit_reg] | level;
                        if (bit_reg == 3'd7)
                        begin
                            tick_next = cfg.stop_delay;
                            bit_next  = '0;
                        end
                        else
                        begin
                            tick_next = cfg.bit_delay;
                            bit_next  = bit_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        tick_next = tick_reg - 1'b1;
                    end
                end
                PH_STOP:
                begin
                    // stop bit level is not checked
                    if (delay_done)
                    begin
                        evt.done = 1'b1;
                    end
                    else
                    begin
                        tick_next = tick_reg - 1'b1;
                    end
                end
                default:
                begin
                    tick_next = tick_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= '0;
            bit_reg   <= '0;
            shift_reg <= '0;
            last_reg  <= 1'b1;
        end
        else if (tick)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            last_reg  <= level;
        end
    end

endmodule

// ===== hdl/urrb_checker.sv =====
`timescale 1ns / 1ps

module urrb_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input urrb_pkg::out_item_t              out_data
);

    import urrb_pkg::*;

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result beat changed while stalled");

    // every accepted input beat yields a result beat next cycle
    a_in_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> out_valid)
        else $error("accepted beat produced no result");

    // a stored byte ends the frame
    a_store_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.byte_stored |-> !out_data.receiving)
        else $error("byte stored while frame still in progress");

    // no byte without a successful read or peek
    a_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.data_valid |-> out_data.data_byte == 8'd0)
        else $error("data byte nonzero without data_valid");

endmodule

bind uart_receiver_with_ring_buffer urrb_checker u_urrb_checker (.*);

// ===== sim/uart_receiver_with_ring_buffer_tb.sv =====
`timescale 1ns / 1ps

module uart_receiver_with_ring_buffer_tb;

    import urrb_pkg::*;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 6;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_LEN     = 300;
    localparam int TIMEOUT_NS   = 10_000_000;
    localparam int DELAY_MAX    = (1 << DELAY_W) - 1;

    // no register lives at this index; writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid = 1'b0;
    logic                  in_ready;
    in_item_t              in_data = '0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    out_item_t             out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    uart_receiver_with_ring_buffer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Receiver shadow: registers, ring, frame state
    int         m_center = 114;
    int         m_bit = 236;
    int         m_stop = 236;
    logic       m_invert = 1'b0;
    logic       m_enable = 1'b1;
    logic [7:0] ring_copy [BUFFER_DEPTH];
    int         rd_ptr = 0;
    int         wr_ptr = 0;
    logic       dropped = 1'b0;
    phase_t     fphase = PH_IDLE;
    int         ticks_left = 0;
    int         bit_pos = 0;
    logic [7:0] shifter = '0;
    logic       line_prev = 1'b1;

    in_item_t  line_items[$];
    out_item_t expected_results[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    logic hold_armed = 1'b0;
    int hold_cycles = 0;

    int items_queued = 0;
    int frames_queued = 0;
    int host_ops = 0;
    int settings_used = 0;
    int beats_in = 0;
    int results_seen = 0;
    int fail_count = 0;

    function automatic bit delay_over();
        if (ticks_left > 1)
        begin
            ticks_left--;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    task automatic predict_beat(input in_item_t beat);
        out_item_t  res;
        logic       prev;
        logic [7:0] rx_byte;
        res = '0;
        if (m_enable)
        begin
            if ((beat.req_type == REQ_READ || beat.req_type == REQ_PEEK) && rd_ptr != wr_ptr)
            begin
                res.data_valid = 1'b1;
                res.data_byte  = ring_copy[rd_ptr];
                if (beat.req_type == REQ_READ)
                    rd_ptr = (rd_ptr + 1) % BUFFER_DEPTH;
            end
            else if (beat.req_type == REQ_FLUSH)
            begin
                rd_ptr = 0;
                wr_ptr = 0;
            end
        end

        prev = line_prev;
        line_prev = beat.rx_level;
        if (!m_enable)
            fphase = PH_IDLE;
        else
        begin
            case (fphase)
                PH_IDLE:
                begin
                    // start on a change of the line to the start level only
                    if (beat.rx_level != prev && beat.rx_level == m_invert)
                    begin
                        fphase     = PH_CENTER;
                        ticks_left = m_center;
                        bit_pos    = 0;
                        shifter    = '0;
                    end
                end
                PH_CENTER:
                begin
                    if (delay_over())
                    begin
                        fphase     = PH_DATA;
                        ticks_left = m_bit;
                    end
                end
                PH_DATA:
                begin
                    if (delay_over())
                    begin
                        shifter[bit_pos] = beat.rx_level;
                        if (bit_pos == 7)
                        begin
                            fphase     = PH_STOP;
                            ticks_left = m_stop;
                            bit_pos    = 0;
                        end
                        else
                        begin
                            bit_pos++;
                            ticks_left = m_bit;
                        end
                    end
                end
                default:
                begin
                    // stop bit is never checked
                    if (delay_over())
                    begin
                        rx_byte = m_invert ? ~shifter : shifter;
                        if ((wr_ptr + 1) % BUFFER_DEPTH != rd_ptr)
                        begin
                            ring_copy[wr_ptr] = rx_byte;
                            wr_ptr = (wr_ptr + 1) % BUFFER_DEPTH;
                            res.byte_stored = 1'b1;
                        end
                        else
                            dropped = 1'b1;
                        fphase = PH_IDLE;
                    end
                end
            endcase
        end

        res.fill_count = m_enable ? FILL_W'((wr_ptr + BUFFER_DEPTH - rd_ptr) % BUFFER_DEPTH) : '0;
        res.overflow   = dropped;
        res.receiving  = (fphase != PH_IDLE);
        expected_results.push_back(res);
    endtask

    function automatic string show_result(input out_item_t r);
        return $sformatf("valid=%0b byte=%02h fill=%0d ovf=%0b stored=%0b rx=%0b",
                         r.data_valid, r.data_byte, r.fill_count, r.overflow,
                         r.byte_stored, r.receiving);
    endfunction

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= 10)
            $display("%0t: %s", $time, what);
    endtask

    // Driver: offer the next queued line sample, predict on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_beat(in_data);
                beats_in++;
            end
            if (!in_valid || in_ready)
            begin
                if (line_items.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_valid <= 1'b1;
                    in_data  <= line_items.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Output side ready, with a one-shot long hold-off when armed
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else if (hold_armed && hold_cycles < HOLD_LEN)
        begin
            out_ready   <= 1'b0;
            hold_cycles <= hold_cycles + 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: compare each result beat with the oldest prediction
    always @(posedge clk)
    begin : monitor
        out_item_t want;
        string     fields;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (expected_results.size() == 0)
                note_failure($sformatf("unexpected result: %s", show_result(out_data)));
            else
            begin
                want = expected_results.pop_front();
                fields = "";
                if (out_data.data_valid !== want.data_valid)
                    fields = {fields, " data_valid"};
                if (out_data.data_byte !== want.data_byte)
                    fields = {fields, " data_byte"};
                if (out_data.fill_count !== want.fill_count)
                    fields = {fields, " fill_count"};
                if (out_data.overflow !== want.overflow)
                    fields = {fields, " overflow"};
                if (out_data.byte_stored !== want.byte_stored)
                    fields = {fields, " byte_stored"};
                if (out_data.receiving !== want.receiving)
                    fields = {fields, " receiving"};
                if (fields != "")
                    note_failure($sformatf("result %0d mismatch on%s: expected %s, got %s",
                                           results_seen, fields, show_result(want),
                                           show_result(out_data)));
            end
        end
    end

    task automatic push_item(input req_t r, input logic lvl);
        in_item_t it;
        it.req_type = r;
        it.rx_level = lvl;
        line_items.push_back(it);
        items_queued++;
        if (r != REQ_TICK)
            host_ops++;
    endtask

    function automatic req_t pick_host(input int pct);
        int roll;
        if ($urandom_range(99) >= pct)
            return REQ_TICK;
        roll = $urandom_range(99);
        if (roll < 50)
            return REQ_READ;
        if (roll < 85)
            return REQ_PEEK;
        return REQ_FLUSH;
    endfunction

    // One well-formed 8N1 frame at the current timing, host requests mixed in
    task automatic queue_frame(input logic [7:0] value, input int host_pct);
        logic idle_lvl;
        int   c_len;
        int   b_len;
        int   s_len;
        idle_lvl = ~m_invert;
        c_len = (m_center == 0) ? 1 : m_center;
        b_len = (m_bit == 0) ? 1 : m_bit;
        s_len = (m_stop == 0) ? 1 : m_stop;
        push_item(pick_host(host_pct), idle_lvl);
        repeat (c_len + 1) push_item(pick_host(host_pct), ~idle_lvl);
        for (int k = 0; k < 8; k++)
            repeat (b_len) push_item(pick_host(host_pct), value[k] ^ m_invert);
        repeat (s_len) push_item(pick_host(host_pct), idle_lvl);
        frames_queued++;
    endtask

    // Random glitches, then hold the line idle long enough for any frame to end
    task automatic queue_noise();
        int settle;
        repeat ($urandom_range(6, 1))
            push_item(req_t'($urandom_range(3)), 1'($urandom_range(1)));
        settle = m_center + 8 * m_bit + m_stop + 4;
        repeat (settle) push_item(pick_host(20), ~m_invert);
    endtask

    task automatic queue_traffic(input int n);
        int start;
        start = items_queued;
        while (items_queued - start < n)
        begin
            if ($urandom_range(99) < 80)
                queue_frame(8'($urandom()), 15);
            else
                queue_noise();
        end
    endtask

    task automatic set_traffic(input int send_pct, input int stall_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = stall_pct;
    endtask

    // wait until every queued beat is accepted and every result is taken
    task automatic drain();
        while (beats_in != items_queued || expected_results.size() != 0 || out_valid)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_DATA_W'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CENTER_DELAY: m_center = value & DELAY_MAX;
            CFG_BIT_DELAY:    m_bit = value & DELAY_MAX;
            CFG_STOP_DELAY:   m_stop = value & DELAY_MAX;
            CFG_INVERT_LINE:  m_invert = value[0];
            CFG_RX_ENABLE:
            begin
                // enabling empties the ring and clears the sticky flag
                if (value[0] && !m_enable)
                begin
                    rd_ptr  = 0;
                    wr_ptr  = 0;
                    dropped = 1'b0;
                end
                m_enable = value[0];
            end
            default: ;
        endcase
    endtask

    task automatic set_timing(input int c, input int b, input int s, input logic inv);
        write_reg(CFG_CENTER_DELAY, c);
        write_reg(CFG_BIT_DELAY, b);
        write_reg(CFG_STOP_DELAY, s);
        write_reg(CFG_INVERT_LINE, inv);
        settings_used++;
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // host requests on the empty ring at reset timing
        push_item(REQ_READ, 1'b1);
        push_item(REQ_PEEK, 1'b1);
        push_item(REQ_FLUSH, 1'b1);
        drain();

        set_timing(1, 1, 1, 1'b0);
        write_reg(CFG_RX_ENABLE, 1);
        queue_frame(8'h00, 0);
        queue_frame(8'hFF, 0);
        push_item(REQ_PEEK, 1'b1);
        push_item(REQ_READ, 1'b1);
        push_item(REQ_READ, 1'b1);
        push_item(REQ_READ, 1'b1);
        drain();

        queue_traffic(40);
        drain();

        set_timing(2, 3, 2, 1'b1);
        set_traffic(62, 0);
        queue_traffic(40);
        drain();

        // zero delays act as one tick; long output hold-off backs up the input
        set_timing(0, 2, 0, 1'b0);
        set_traffic(0, 62);
        hold_armed <= 1'b1;
        queue_traffic(40);
        drain();

        set_timing(3, 1, 4, 1'b1);
        set_traffic(9, 9);
        queue_traffic(40);
        drain();

        // fill the ring past capacity, then drain it
        set_timing(1, 1, 1, 1'b0);
        set_traffic(0, 0);
        repeat (BUFFER_DEPTH + 2) queue_frame(8'($urandom()), 0);
        repeat (BUFFER_DEPTH + 2) push_item(REQ_READ, 1'b1);
        push_item(REQ_PEEK, 1'b1);
        queue_frame(8'h5A, 0);
        push_item(REQ_FLUSH, 1'b1);
        push_item(REQ_PEEK, 1'b1);
        // leave a frame in progress for the disable to abandon
        push_item(REQ_TICK, 1'b0);
        push_item(REQ_TICK, 1'b0);
        drain();

        write_reg(CFG_RX_ENABLE, 0);
        set_traffic(9, 9);
        queue_frame(8'h3C, 30);
        push_item(REQ_READ, 1'b1);
        push_item(REQ_PEEK, 1'b0);
        push_item(REQ_FLUSH, 1'b0);
        drain();
        write_reg(CFG_UNUSED, DELAY_MAX);
        write_reg(CFG_RX_ENABLE, 1);
        push_item(REQ_PEEK, 1'b1);
        push_item(REQ_READ, 1'b1);
        queue_frame(8'hC3, 10);
        push_item(REQ_READ, 1'b1);
        drain();

        // longest delays: start a frame, count down a while, then abandon it
        set_timing(DELAY_MAX, DELAY_MAX, DELAY_MAX, 1'b1);
        set_traffic(0, 0);
        push_item(REQ_TICK, 1'b0);
        repeat (8) push_item(pick_host(30), 1'b1);
        drain();
        write_reg(CFG_RX_ENABLE, 0);
        write_reg(CFG_RX_ENABLE, 1);

        set_timing(2, 2, 1, 1'b1);
        set_traffic(62, 62);
        queue_traffic(40);
        drain();

        if (expected_results.size() != 0)
            note_failure($sformatf("%0d expected results never arrived",
                                   expected_results.size()));

        $display("%0d beats sent, %0d results checked: %0d frames, %0d host requests,",
                 beats_in, results_seen, frames_queued, host_ops);
        $display("%0d timing settings incl. zero and max delays, both line polarities, overflow, disable",
                 settings_used);
        if (fail_count == 0)
            $display("uart_receiver_with_ring_buffer_tb: done, clean");
        else
            $display("uart_receiver_with_ring_buffer_tb: done, errors");
        $finish;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout after %0d results", results_seen);
        $display("uart_receiver_with_ring_buffer_tb: done, errors");
        $finish;
    end

endmodule
